// File: rtl/core/twr_pkg.sv
// Shared types and constants of the topic wildcard rewriter.
package twr_pkg;

  // Default pattern depth looked at by the plus bitmap
  localparam int MaxLevels = 64;

  // Most results one byte can cause, and depth of the result queue
  localparam int MaxRes    = 3;
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  // Configuration register indexes
  localparam logic [1:0] CfgPlusMask = 2'd0;
  localparam logic [1:0] CfgHashLvl  = 2'd1;
  localparam logic [1:0] CfgPatLvls  = 2'd2;

  // Rewrite modes
  localparam logic [2:0] ModeStart   = 3'd0;
  localparam logic [2:0] ModeCopy    = 3'd1;
  localparam logic [2:0] ModeReplace = 3'd2;
  localparam logic [2:0] ModeDone    = 3'd3;
  localparam logic [2:0] ModeNoWild  = 3'd4;

  // Verdict codes
  localparam logic [1:0] VerPending    = 2'd0;
  localparam logic [1:0] VerApplies    = 2'd1;
  localparam logic [1:0] VerNotApplies = 2'd2;
  localparam logic [1:0] VerNoWild     = 2'd3;

  // Characters
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChPlus  = 8'h2B;

  typedef struct packed {
    logic [63:0] plus_mask;
    logic [6:0]  hash_level;
    logic [6:0]  pattern_levels;
  } cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] level_count;
    logic       void_flag;
  } rw_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_output;
    logic [1:0] verdict;
  } res_t;

  typedef struct packed {
    logic [1:0]        num;
    res_t [MaxRes-1:0] res;
  } step_res_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            room;
  } fifo_stat_t;

endpackage

// File: rtl/core/twr_step.sv
// Per-byte rewrite logic: next state and up to three results.
module twr_step #(
  parameter int MaxLvls = twr_pkg::MaxLevels
) (
  input  twr_pkg::cfg_t      cfg_i,
  input  twr_pkg::rw_state_t state_i,
  input  logic [7:0]         topic_byte_i,
  input  logic               final_byte_i,
  output twr_pkg::rw_state_t state_o,
  output twr_pkg::step_res_t step_o
);
  import twr_pkg::*;

  // Plus bits that lie within the looked-at levels
  localparam logic [63:0] LvlMsk = (MaxLvls >= 64) ? {64{1'b1}} :
                                   ((64'd1 << MaxLvls) - 64'd1);

  function automatic logic lvl_plus(logic [63:0] m, logic [6:0] l);
    logic [6:0] idx;
    idx = l - 7'd1;
    return (l != 7'd0) && (l <= 7'(MaxLvls)) && m[idx[5:0]];
  endfunction

  function automatic logic lvl_hash(cfg_t c, logic [6:0] l);
    return (c.hash_level != 7'd0) && (l == c.hash_level);
  endfunction

  function automatic logic plus_above(logic [63:0] m, logic [6:0] l);
    return |(m & LvlMsk & ({64{1'b1}} << l));
  endfunction

  function automatic rw_state_t open_level(cfg_t c, rw_state_t s);
    rw_state_t r;
    r = s;
    if (s.level_count >= c.pattern_levels) begin
      r.mode      = ModeDone;
      r.void_flag = 1'b1;
    end else begin
      r.level_count = s.level_count + 7'd1;
      r.mode = (lvl_plus(c.plus_mask, r.level_count) || lvl_hash(c, r.level_count)) ?
               ModeReplace : ModeCopy;
    end
    return r;
  endfunction

  function automatic res_t mk_res(logic [7:0] b, logic v, logic e, logic [1:0] ver);
    res_t r;
    r.out_byte      = b;
    r.byte_valid    = v;
    r.end_of_output = e;
    r.verdict       = ver;
    return r;
  endfunction

  rw_state_t  st;
  step_res_t  so;
  logic [1:0] k;
  logic       any_wild;

  assign any_wild = (|(cfg_i.plus_mask & LvlMsk)) || (cfg_i.hash_level != 7'd0);

  always_comb begin
    st = state_i;
    so = '0;
    k  = 2'd0;

    // first byte of a topic: judge the pattern
    if (st.mode == ModeStart) begin
      st.level_count = 7'd1;
      st.void_flag   = 1'b0;
      if (!any_wild) begin
        st.mode = ModeNoWild;
      end else begin
        st.mode = (lvl_plus(cfg_i.plus_mask, 7'd1) || lvl_hash(cfg_i, 7'd1)) ?
                  ModeReplace : ModeCopy;
      end
    end

    // byte handling
    case (st.mode)
      ModeCopy: begin
        so.res[k] = mk_res(topic_byte_i, 1'b1, 1'b0, VerPending);
        k = k + 2'd1;
        if (topic_byte_i == ChSlash) st = open_level(cfg_i, st);
      end
      ModeReplace: begin
        if (topic_byte_i == ChSlash) begin
          if (lvl_hash(cfg_i, st.level_count)) begin
            so.res[k] = mk_res(ChHash, 1'b1, 1'b0, VerPending);
            k = k + 2'd1;
            st.mode      = ModeDone;
            st.void_flag = 1'b0;
          end else begin
            so.res[k] = mk_res(ChPlus, 1'b1, 1'b0, VerPending);
            k = k + 2'd1;
            so.res[k] = mk_res(ChSlash, 1'b1, 1'b0, VerPending);
            k = k + 2'd1;
            st = open_level(cfg_i, st);
          end
        end
      end
      default: ;
    endcase

    // last byte: closing word with the verdict
    if (final_byte_i) begin
      case (st.mode)
        ModeDone: begin
          so.res[k] = mk_res(8'd0, 1'b0, 1'b1,
                             st.void_flag ? VerNotApplies : VerApplies);
        end
        ModeNoWild: begin
          so.res[k] = mk_res(8'd0, 1'b0, 1'b1, VerNoWild);
        end
        ModeCopy: begin
          so.res[k] = mk_res(8'd0, 1'b0, 1'b1,
                             (st.level_count < cfg_i.pattern_levels) ?
                             VerNotApplies : VerApplies);
        end
        default: begin
          if (lvl_hash(cfg_i, st.level_count)) begin
            so.res[k] = mk_res(ChHash, 1'b1, 1'b1, VerApplies);
          end else if (plus_above(cfg_i.plus_mask, st.level_count) ||
                       (st.level_count < cfg_i.pattern_levels)) begin
            so.res[k] = mk_res(8'd0, 1'b0, 1'b1, VerNotApplies);
          end else begin
            so.res[k] = mk_res(ChPlus, 1'b1, 1'b1, VerApplies);
          end
        end
      endcase
      k = k + 2'd1;
      st.mode        = ModeStart;
      st.level_count = 7'd1;
      st.void_flag   = 1'b0;
    end

    so.num = k;
  end

  assign state_o = st;
  assign step_o  = so;

endmodule

// File: rtl/core/twr_res_fifo.sv
// Result queue: takes up to three words a cycle, hands out one when the reader is ready.
module twr_res_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  twr_pkg::step_res_t    push_data_i,
  input  logic                  pop_ready_i,
  output logic                  pop_valid_o,
  output twr_pkg::res_t         pop_data_o,
  output twr_pkg::fifo_stat_t   stat_o
);
  import twr_pkg::*;

  res_t            ent_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] push_n;
  logic            pop;

  assign push_n      = push_i ? CntW'(push_data_i.num) : '0;
  assign pop_valid_o = (cnt_q != '0);
  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_data_o  = ent_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_n);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + push_n - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry writes, consecutive slots from the write pointer
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (i < int'(push_n)) begin
        ent_q[wr_ptr_q + PtrW'(i)] <= push_data_i.res[i];
      end
    end
  end

  assign stat_o.count = cnt_q;
  assign stat_o.room  = (cnt_q <= CntW'(FifoDepth - MaxRes));

endmodule

// File: rtl/core/topic_wildcard_rewriter.sv
// Top level: config registers, input register, rewrite state and result queue.
// A byte's result words pass through the input register and then the result queue.
// Throughput: one byte per cycle while each byte yields one word and the output
// takes one; a closed plus level yields two words and a final byte adds a closing
// word, drained one word per cycle while the output is ready, through a four-word
// result queue, which holds off input when under three free.
// Reset: asynchronous; clears config registers, rewrite state and the queue.
module topic_wildcard_rewriter #(
  parameter int MaxLvls = twr_pkg::MaxLevels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] topic_byte
  input  logic        s_axis_tlast,   // final_byte
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,   // [0] byte_valid, [2:1] verdict
  output logic        m_axis_tlast,   // end_of_output
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [63:0] cfg_data_i
);
  import twr_pkg::*;

  cfg_t       cfg_q;
  rw_state_t  st_q, st_d;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_final_q;
  logic       advance;
  step_res_t  step_res;
  fifo_stat_t fstat;
  res_t       head;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgPlusMask: cfg_q.plus_mask      <= cfg_data_i;
        CfgHashLvl:  cfg_q.hash_level     <= cfg_data_i[6:0];
        CfgPatLvls:  cfg_q.pattern_levels <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // input register
  assign advance       = in_valid_q && fstat.room;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_final_q <= s_axis_tlast;
    end
  end

  // rewrite logic
  twr_step #(
    .MaxLvls (MaxLvls)
  ) u_step (
    .cfg_i        (cfg_q),
    .state_i      (st_q),
    .topic_byte_i (in_byte_q),
    .final_byte_i (in_final_q),
    .state_o      (st_d),
    .step_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode        <= ModeStart;
      st_q.level_count <= 7'd1;
      st_q.void_flag   <= 1'b0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // result queue
  twr_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .push_data_i (step_res),
    .pop_ready_i (m_axis_tready),
    .pop_valid_o (m_axis_tvalid),
    .pop_data_o  (head),
    .stat_o      (fstat)
  );

  assign m_axis_tdata = head.out_byte;
  assign m_axis_tuser = {head.verdict, head.byte_valid};
  assign m_axis_tlast = head.end_of_output;

  // checks
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.count <= CntW'(FifoDepth))
    else $error("result queue overfilled");

  a_final_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_final_q |=> st_q.mode == ModeStart && st_q.level_count == 7'd1)
    else $error("state not back at topic start after final byte");

  a_level_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.level_count != 7'd0)
    else $error("level count reached zero");

  a_final_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_final_q |-> step_res.num != 2'd0 &&
      step_res.res[step_res.num - 2'd1].end_of_output)
    else $error("final byte without closing word");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the topic wildcard rewriter: random topics, random stalls, live predictor.
module tb_top;
  import twr_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int DrainWait  = 10;
  localparam int RandBytes  = 450;
  localparam int MaxPrints  = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } topic_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = CfgPlusMask;
  logic [63:0] cfg_data_i = 64'd0;

  topic_wildcard_rewriter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Pending topic bytes, predicted result words, bookkeeping
  topic_word_t topic_q[$];
  res_t        rewritten_q[$];
  int          bytes_out = 0;
  int          rand_bytes = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  bit          byte_taken = 1'b0;
  bit          steady = 1'b0;
  int          src_gap = 0;
  int          snk_stall = 0;

  // Predictor copy of the pattern registers and rewrite state
  logic [63:0] pat_plus = 64'd0;
  logic [6:0]  pat_hash = 7'd0;
  logic [6:0]  pat_depth = 7'd0;
  logic [2:0]  rw_mode = ModeStart;
  logic [6:0]  rw_lvl = 7'd1;
  logic        rw_void = 1'b0;

  task automatic report(input string msg);
    if (err_cnt < MaxPrints) $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic bit lvl_plus(input int l);
    if (l < 1 || l > MaxLevels) return 1'b0;
    return pat_plus[l-1];
  endfunction

  function automatic bit lvl_hash(input int l);
    return pat_hash != 7'd0 && l == int'(pat_hash);
  endfunction

  function automatic bit plus_above(input int l);
    for (int i = l + 1; i <= MaxLevels; i++)
      if (lvl_plus(i)) return 1'b1;
    return 1'b0;
  endfunction

  task automatic push_res(input logic [7:0] b, input logic vld, input logic eoo,
                          input logic [1:0] ver);
    res_t r;
    r.out_byte = b;
    r.byte_valid = vld;
    r.end_of_output = eoo;
    r.verdict = ver;
    rewritten_q.insert(rewritten_q.size(), r);
  endtask

  // '/' opening the next level: past the pattern depth the topic is void
  task automatic open_level();
    if (rw_lvl >= pat_depth) begin
      rw_mode = ModeDone;
      rw_void = 1'b1;
    end else begin
      rw_lvl = rw_lvl + 7'd1;
      rw_mode = (lvl_plus(rw_lvl) || lvl_hash(rw_lvl)) ? ModeReplace : ModeCopy;
    end
  endtask

  // Expected words for one accepted topic byte
  task automatic rewrite_byte(input logic [7:0] c, input logic fin);
    if (rw_mode == ModeStart) begin
      rw_lvl = 7'd1;
      rw_void = 1'b0;
      if (!plus_above(0) && pat_hash == 7'd0) rw_mode = ModeNoWild;
      else rw_mode = (lvl_plus(1) || lvl_hash(1)) ? ModeReplace : ModeCopy;
    end
    if (rw_mode == ModeCopy) begin
      push_res(c, 1'b1, 1'b0, VerPending);
      if (c == ChSlash) open_level();
    end else if (rw_mode == ModeReplace && c == ChSlash) begin
      if (lvl_hash(rw_lvl)) begin
        push_res(ChHash, 1'b1, 1'b0, VerPending);
        rw_mode = ModeDone;
        rw_void = 1'b0;
      end else begin
        push_res(ChPlus, 1'b1, 1'b0, VerPending);
        push_res(ChSlash, 1'b1, 1'b0, VerPending);
        open_level();
      end
    end
    if (fin) begin
      case (rw_mode)
        ModeDone:   push_res(8'h00, 1'b0, 1'b1, rw_void ? VerNotApplies : VerApplies);
        ModeNoWild: push_res(8'h00, 1'b0, 1'b1, VerNoWild);
        ModeCopy:   push_res(8'h00, 1'b0, 1'b1,
                             (rw_lvl < pat_depth) ? VerNotApplies : VerApplies);
        default: begin
          if (lvl_hash(rw_lvl)) push_res(ChHash, 1'b1, 1'b1, VerApplies);
          else if (plus_above(rw_lvl) || rw_lvl < pat_depth)
            push_res(8'h00, 1'b0, 1'b1, VerNotApplies);
          else push_res(ChPlus, 1'b1, 1'b1, VerApplies);
        end
      endcase
      rw_mode = ModeStart;
      rw_lvl = 7'd1;
      rw_void = 1'b0;
    end
  endtask

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Input driver
  always @(negedge clk_i) begin
    topic_word_t w;
    if (s_axis_tvalid && !byte_taken) begin
      // hold the offered word
    end else if (src_gap > 0) begin
      src_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (topic_q.size() > 0) begin
      w = topic_q.pop_front();
      s_axis_tdata <= w.data;
      s_axis_tlast <= w.last;
      s_axis_tvalid <= 1'b1;
      src_gap = pick_gap();
    end else begin
      s_axis_tvalid <= 1'b0;
    end
    byte_taken = 1'b0;
  end

  // Output backpressure
  always @(negedge clk_i) begin
    if (snk_stall > 0) begin
      snk_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      snk_stall = pick_gap();
    end
  end

  // Monitor: check result words, then predict for the accepted topic byte
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.out_byte = m_axis_tdata;
      got.byte_valid = m_axis_tuser[0];
      got.end_of_output = m_axis_tlast;
      got.verdict = m_axis_tuser[2:1];
      if (rewritten_q.size() == 0) begin
        report($sformatf("unexpected word byte=%h vld=%b end=%b ver=%0d",
                         got.out_byte, got.byte_valid, got.end_of_output, got.verdict));
      end else begin
        want = rewritten_q.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
            got.end_of_output !== want.end_of_output || got.verdict !== want.verdict)
          report($sformatf("word byte=%h vld=%b end=%b ver=%0d, expected %h %b %b %0d",
                           got.out_byte, got.byte_valid, got.end_of_output, got.verdict,
                           want.out_byte, want.byte_valid, want.end_of_output,
                           want.verdict));
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      rewrite_byte(s_axis_tdata, s_axis_tlast);
      bytes_out--;
      byte_taken = 1'b1;
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("** topic_wildcard_rewriter: FAILED **");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgPlusMask: pat_plus = val;
      CfgHashLvl:  pat_hash = val[6:0];
      default:     pat_depth = val[6:0];
    endcase
  endtask

  task automatic set_pattern(input logic [63:0] plus, input int hash, input int depth);
    write_reg(CfgPlusMask, plus);
    write_reg(CfgHashLvl, 64'(hash));
    write_reg(CfgPatLvls, 64'(depth));
  endtask

  task automatic push_word(input logic [7:0] b, input logic last);
    topic_word_t w;
    w.data = b;
    w.last = last;
    topic_q.insert(topic_q.size(), w);
    bytes_out++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i], i == s.len() - 1);
  endtask

  // Wait for every byte taken and every word seen, then let the pipe settle
  task automatic wait_idle();
    while (bytes_out != 0 || rewritten_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Level text: any byte but '/', with wildcard characters now and then
  function automatic logic [7:0] text_byte();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 9);
    if (r == 0) return ChPlus;
    if (r == 1) return ChHash;
    b = 8'($urandom_range(0, 255));
    if (b == ChSlash) b = b ^ 8'h01;
    return b;
  endfunction

  // Well-formed topic of a given level count
  task automatic queue_topic(input int levels, input int maxlen);
    logic [7:0] txt[$];
    int n;
    for (int k = 1; k <= levels; k++) begin
      if (k > 1) txt.insert(txt.size(), ChSlash);
      n = $urandom_range(0, maxlen);
      for (int j = 0; j < n; j++) txt.insert(txt.size(), text_byte());
    end
    if (txt.size() == 0) txt.insert(txt.size(), text_byte());
    foreach (txt[j]) push_word(txt[j], j == txt.size() - 1);
    rand_bytes += txt.size();
  endtask

  // Noise topic: raw bytes with frequent slashes
  task automatic queue_noise();
    int n;
    logic [7:0] b;
    n = $urandom_range(1, 6);
    for (int j = 0; j < n; j++) begin
      b = ($urandom_range(0, 9) < 3) ? ChSlash : 8'($urandom_range(0, 255));
      push_word(b, j == n - 1);
    end
    rand_bytes += n;
  endtask

  // Random pattern: mostly consistent shallow ones, plus extremes and odd mixes
  task automatic random_pattern(output int depth);
    logic [63:0] m;
    int h;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      depth = $urandom_range(1, 8);
      m = {$urandom, $urandom} & ((64'd1 << depth) - 64'd1);
      h = $urandom_range(0, 1) ? depth : 0;
    end else if (kind == 6) begin
      depth = 64;
      h = $urandom_range(0, 1) ? 64 : 0;
      m = $urandom_range(0, 1) ? {64{1'b1}} : {$urandom, $urandom};
    end else if (kind == 7) begin
      depth = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 64);
      h = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 64);
      m = {$urandom, $urandom};
    end else if (kind == 8) begin
      // not a wildcard
      depth = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 64);
      h = 0;
      m = 64'd0;
    end else begin
      // lone plus bit, possibly far above the depth
      depth = $urandom_range(1, 8);
      h = 0;
      m = 64'd1 << $urandom_range(0, 63);
    end
    set_pattern(m, h, depth);
  endtask

  // Stimulus and end of run
  initial begin
    int depth;
    int topics;
    int lv;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Registers at reset: not a wildcard
    push_word(8'h00, 1'b1);
    wait_idle();

    // Plus at 1 and 3, hash at 4: hash ends the rewrite, tail taken silently
    set_pattern(64'h5, 4, 4);
    push_word(8'hFF, 1'b0);
    push_word(ChSlash, 1'b0);
    push_word(8'h00, 1'b0);
    push_text("/c/d/e");
    push_text("q/r");
    wait_idle();

    // All plus bits, depth one: plus beyond the end, and too many levels
    set_pattern({64{1'b1}}, 0, 1);
    push_text("z");
    push_text("z/y");
    wait_idle();

    // Hash at level one, also marked plus: hash wins
    set_pattern(64'h1, 1, 1);
    push_text("/");
    push_text("k");
    wait_idle();

    // Topic ends in the last plus level
    set_pattern(64'h2, 0, 2);
    push_text("a/b");
    wait_idle();

    // Random phases
    while (rand_bytes < RandBytes) begin
      random_pattern(depth);
      steady = ($urandom_range(0, 4) == 0);
      topics = (depth > 16) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      for (int t = 0; t < topics; t++) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_noise();
        end else begin
          if ($urandom_range(0, 9) < 7) lv = depth + $urandom_range(0, 2) - 1;
          else lv = $urandom_range(1, 6);
          if (lv < 1) lv = 1;
          queue_topic(lv, (lv > 10) ? 1 : 3);
        end
      end
      wait_idle();
    end

    if (rewritten_q.size() != 0)
      report($sformatf("%0d expected words never arrived", rewritten_q.size()));
    if (err_cnt == 0) begin
      $display("** topic_wildcard_rewriter: PASSED **");
    end else begin
      $display("** topic_wildcard_rewriter: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/twr_pkg.sv
rtl/core/twr_step.sv
rtl/core/twr_res_fifo.sv
rtl/core/topic_wildcard_rewriter.sv
sim/tb_top.sv
